[sv/dual_motor_ramp_sequencer_core_defines.svh]
// ----------------------------------------------------------------------------
// Dual motor ramp sequencer - assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_MOTOR_RAMP_SEQUENCER_CORE_DEFINES_SVH
`define DUAL_MOTOR_RAMP_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication
`define DMRS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication
`define DMRS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

[sv/dmrs_pkg.sv]
// ----------------------------------------------------------------------------
// dmrs_pkg
// Widths, codes and helpers for the dual motor ramp sequencer.
// ----------------------------------------------------------------------------
package dmrs_pkg;

    localparam int DUTY_BITS       = 16;
    localparam int SENSOR_BITS     = 10;
    localparam int MODE_BITS       = 2;
    localparam int KIND_BITS       = 3;
    localparam int STATE_CODE_BITS = 4;
    localparam int THR_BITS        = SENSOR_BITS + 2;

    localparam int IN_FIELD_BITS   = KIND_BITS + 2 * DUTY_BITS + 2 * SENSOR_BITS;
    localparam int IN_TDATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_CODE_LSB    = 4 * DUTY_BITS;
    localparam int OUT_FAULT_POS   = OUT_CODE_LSB + STATE_CODE_BITS;
    localparam int OUT_FIELD_BITS  = OUT_FAULT_POS + 1;
    localparam int OUT_TDATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam int CFG_ADDR_BITS   = 3;
    localparam int CFG_DATA_BITS   = (DUTY_BITS > SENSOR_BITS) ? DUTY_BITS : SENSOR_BITS;

    localparam int RAMP_STEP_RST   = 1000;
    localparam int BLACK_LEVEL_RST = 800;
    localparam int WHITE_LEVEL_RST = 200;
    localparam int FAST_DUTY_RST   = 40000;
    localparam int SLOW_DUTY_RST   = 20000;

    localparam int BLACK_MARGIN    = 200;
    localparam int BLACK_WIDE      = 250;
    localparam int WHITE_MARGIN    = 150;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_TICK   = 2'd0,
        MODE_CMD    = 2'd1,
        MODE_FOLLOW = 2'd2
    } mode_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_FWD  = 3'd1,
        KIND_REV  = 3'd2,
        KIND_CW   = 3'd3,
        KIND_STOP = 3'd4,
        KIND_ACW  = 3'd5
    } kind_t;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_RAMP_STEP   = 3'd0,
        CFG_BLACK_LEVEL = 3'd1,
        CFG_WHITE_LEVEL = 3'd2,
        CFG_FAST_DUTY   = 3'd3,
        CFG_SLOW_DUTY   = 3'd4
    } cfg_addr_t;

    typedef enum logic [12:0] {
        ST_IDLE       = 13'b0_0000_0000_0001,
        ST_CONFIGURE  = 13'b0_0000_0000_0010,
        ST_FWD_START  = 13'b0_0000_0000_0100,
        ST_FWD_ADJUST = 13'b0_0000_0000_1000,
        ST_REV_START  = 13'b0_0000_0001_0000,
        ST_REV_ADJUST = 13'b0_0000_0010_0000,
        ST_CW_START   = 13'b0_0000_0100_0000,
        ST_CW_ADJUST  = 13'b0_0000_1000_0000,
        ST_ACW_START  = 13'b0_0001_0000_0000,
        ST_ACW_ADJUST = 13'b0_0010_0000_0000,
        ST_INIT_STOP  = 13'b0_0100_0000_0000,
        ST_STOP       = 13'b0_1000_0000_0000,
        ST_FOLLOW     = 13'b1_0000_0000_0000
    } state_t;

    typedef enum logic [STATE_CODE_BITS-1:0] {
        CODE_IDLE       = 4'd0,
        CODE_CONFIGURE  = 4'd1,
        CODE_FWD_START  = 4'd2,
        CODE_FWD_ADJUST = 4'd3,
        CODE_REV_START  = 4'd4,
        CODE_REV_ADJUST = 4'd5,
        CODE_CW_START   = 4'd6,
        CODE_CW_ADJUST  = 4'd7,
        CODE_ACW_START  = 4'd8,
        CODE_ACW_ADJUST = 4'd9,
        CODE_INIT_STOP  = 4'd10,
        CODE_STOP       = 4'd11,
        CODE_FOLLOW     = 4'd12
    } state_code_t;

    function automatic state_code_t state_code(input state_t st);
        state_code_t c;
        unique case (st)
            ST_IDLE:       c = CODE_IDLE;
            ST_CONFIGURE:  c = CODE_CONFIGURE;
            ST_FWD_START:  c = CODE_FWD_START;
            ST_FWD_ADJUST: c = CODE_FWD_ADJUST;
            ST_REV_START:  c = CODE_REV_START;
            ST_REV_ADJUST: c = CODE_REV_ADJUST;
            ST_CW_START:   c = CODE_CW_START;
            ST_CW_ADJUST:  c = CODE_CW_ADJUST;
            ST_ACW_START:  c = CODE_ACW_START;
            ST_ACW_ADJUST: c = CODE_ACW_ADJUST;
            ST_INIT_STOP:  c = CODE_INIT_STOP;
            ST_STOP:       c = CODE_STOP;
            ST_FOLLOW:     c = CODE_FOLLOW;
            default:       c = CODE_IDLE;
        endcase
        return c;
    endfunction

    // one ramp step up toward target, clamped at it; at or above target jumps straight to it; zero target forces off
    function automatic logic [DUTY_BITS-1:0] ramp_one(
        input logic [DUTY_BITS-1:0] d,
        input logic [DUTY_BITS-1:0] t,
        input logic [DUTY_BITS-1:0] step
    );
        logic [DUTY_BITS:0] sum;
        logic [DUTY_BITS-1:0] r;
        sum = {1'b0, d} + {1'b0, step};
        if (t == '0)
            r = '0;
        else if (d < t)
            r = (sum > {1'b0, t}) ? t : sum[DUTY_BITS-1:0];
        else
            r = t;
        return r;
    endfunction

endpackage

[sv/dual_motor_ramp_sequencer_core.sv]
// ----------------------------------------------------------------------------
// dual_motor_ramp_sequencer_core
// Duty sequencer for a two-motor drive: ramps, stop sequence, line following.
// ----------------------------------------------------------------------------
// Input stream (s_*): one item per tick, motion command or follow start,
// selected by s_tuser. Every accepted item yields exactly one result item on
// the output stream (m_*) carrying the four duties, the state code and the
// sticky fault flag as they stand after that item.
// The state and the result register load at the edge that accepts the item.
// Throughput is one item per cycle while the receiver takes results; the result
// register is the only stage, so s_tready follows the output side.
// When the receiver stalls, the result holds in m_tdata and s_tready drops
// until it is taken; the next item is accepted in the same cycle the held
// result leaves.
// Reset sets the thresholds and duties to their defaults, the sequencer to
// idle, clears the fault and empties the result register.
// Configuration writes take effect at the next edge; the user must make them
// while no item is in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module dual_motor_ramp_sequencer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // motion_kind_in, right_target_in, left_target_in, left_sensor, right_sensor
    input  logic [dmrs_pkg::IN_TDATA_BITS-1:0]  s_tdata,
    // mode
    input  logic [dmrs_pkg::MODE_BITS-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // right_fwd_duty, left_fwd_duty, right_rev_duty, left_rev_duty,
    // state_code, fault_flag
    output logic [dmrs_pkg::OUT_TDATA_BITS-1:0] m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [dmrs_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [dmrs_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
    import dmrs_pkg::*;

    logic [DUTY_BITS-1:0]   ramp_step_reg;
    logic [SENSOR_BITS-1:0] black_level_reg;
    logic [SENSOR_BITS-1:0] white_level_reg;
    logic [DUTY_BITS-1:0]   fast_duty_reg;
    logic [DUTY_BITS-1:0]   slow_duty_reg;

    state_t                 state_reg, state_next;
    logic [KIND_BITS-1:0]   kind_reg, kind_next;
    logic [DUTY_BITS-1:0]   rf_reg, rf_next;
    logic [DUTY_BITS-1:0]   lf_reg, lf_next;
    logic [DUTY_BITS-1:0]   rr_reg, rr_next;
    logic [DUTY_BITS-1:0]   lr_reg, lr_next;
    logic [DUTY_BITS-1:0]   rt_reg, rt_next;
    logic [DUTY_BITS-1:0]   lt_reg, lt_next;
    logic                   fault_reg, fault_next;

    logic                      m_tvalid_reg;
    logic [OUT_TDATA_BITS-1:0] m_tdata_reg, m_tdata_next;

    logic [KIND_BITS-1:0]   in_kind;
    logic [DUTY_BITS-1:0]   in_rt;
    logic [DUTY_BITS-1:0]   in_lt;
    logic [SENSOR_BITS-1:0] in_ls;
    logic [SENSOR_BITS-1:0] in_rs;

    logic                       accept;
    logic                       shoot;
    logic signed [THR_BITS-1:0] ls_s, rs_s, th_blk, th_wide, th_wht;
    logic                       both_on, left_only, right_only;

    assign in_kind = s_tdata[KIND_BITS-1:0];
    assign in_rt   = s_tdata[KIND_BITS +: DUTY_BITS];
    assign in_lt   = s_tdata[KIND_BITS + DUTY_BITS +: DUTY_BITS];
    assign in_ls   = s_tdata[KIND_BITS + 2 * DUTY_BITS +: SENSOR_BITS];
    assign in_rs   = s_tdata[KIND_BITS + 2 * DUTY_BITS + SENSOR_BITS +: SENSOR_BITS];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_step_reg   <= DUTY_BITS'(RAMP_STEP_RST);
            black_level_reg <= SENSOR_BITS'(BLACK_LEVEL_RST);
            white_level_reg <= SENSOR_BITS'(WHITE_LEVEL_RST);
            fast_duty_reg   <= DUTY_BITS'(FAST_DUTY_RST);
            slow_duty_reg   <= DUTY_BITS'(SLOW_DUTY_RST);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_RAMP_STEP:   ramp_step_reg   <= cfg_wdata[DUTY_BITS-1:0];
                CFG_BLACK_LEVEL: black_level_reg <= cfg_wdata[SENSOR_BITS-1:0];
                CFG_WHITE_LEVEL: white_level_reg <= cfg_wdata[SENSOR_BITS-1:0];
                CFG_FAST_DUTY:   fast_duty_reg   <= cfg_wdata[DUTY_BITS-1:0];
                CFG_SLOW_DUTY:   slow_duty_reg   <= cfg_wdata[DUTY_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // signed line-follow thresholds
    always_comb
    begin
        ls_s    = signed'({2'b00, in_ls});
        rs_s    = signed'({2'b00, in_rs});
        th_blk  = signed'({2'b00, black_level_reg}) - signed'(THR_BITS'(BLACK_MARGIN));
        th_wide = signed'({2'b00, black_level_reg}) - signed'(THR_BITS'(BLACK_WIDE));
        th_wht  = signed'({2'b00, white_level_reg}) + signed'(THR_BITS'(WHITE_MARGIN));
        both_on    = (ls_s > th_blk) && (rs_s > th_blk);
        left_only  = (ls_s > th_wide) && (rs_s < th_wht);
        right_only = (rs_s > th_wide) && (ls_s < th_wht);
    end

    assign shoot = ((rf_reg != '0) && (rr_reg != '0)) || ((lf_reg != '0) && (lr_reg != '0));

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        rf_next    = rf_reg;
        lf_next    = lf_reg;
        rr_next    = rr_reg;
        lr_next    = lr_reg;
        rt_next    = rt_reg;
        lt_next    = lt_reg;
        fault_next = fault_reg;
        case (s_tuser)
            MODE_TICK:
            begin
                unique case (state_reg)
                    ST_CONFIGURE:
                    begin
                        case (kind_reg)
                            KIND_FWD:  state_next = ST_FWD_START;
                            KIND_REV:  state_next = ST_REV_START;
                            KIND_CW:   state_next = ST_CW_START;
                            KIND_STOP: state_next = ST_INIT_STOP;
                            KIND_ACW:  state_next = ST_ACW_START;
                            default:   state_next = ST_CONFIGURE;
                        endcase
                    end
                    ST_FWD_START, ST_REV_START, ST_CW_START, ST_ACW_START:
                    begin
                        if (shoot)
                        begin
                            fault_next = 1'b1;
                            state_next = ST_INIT_STOP;
                        end
                        else
                        begin
                            unique case (state_reg)
                                ST_FWD_START: state_next = ST_FWD_ADJUST;
                                ST_REV_START: state_next = ST_REV_ADJUST;
                                ST_CW_START:  state_next = ST_CW_ADJUST;
                                default:      state_next = ST_ACW_ADJUST;
                            endcase
                        end
                    end
                    ST_FWD_ADJUST:
                    begin
                        rf_next = ramp_one(rf_reg, rt_reg, ramp_step_reg);
                        lf_next = ramp_one(lf_reg, lt_reg, ramp_step_reg);
                    end
                    ST_REV_ADJUST:
                    begin
                        rr_next = ramp_one(rr_reg, rt_reg, ramp_step_reg);
                        lr_next = ramp_one(lr_reg, lt_reg, ramp_step_reg);
                    end
                    ST_CW_ADJUST:
                    begin
                        rf_next = ramp_one(rf_reg, rt_reg, ramp_step_reg);
                        lr_next = ramp_one(lr_reg, lt_reg, ramp_step_reg);
                    end
                    ST_ACW_ADJUST:
                    begin
                        lf_next = ramp_one(lf_reg, lt_reg, ramp_step_reg);
                        rr_next = ramp_one(rr_reg, rt_reg, ramp_step_reg);
                    end
                    ST_INIT_STOP:
                        state_next = ST_STOP;
                    ST_STOP:
                    begin
                        rf_next    = '0;
                        lf_next    = '0;
                        rr_next    = '0;
                        lr_next    = '0;
                        kind_next  = '0;
                        state_next = ST_IDLE;
                    end
                    ST_FOLLOW:
                    begin
                        priority if (both_on)
                        begin
                            rf_next = slow_duty_reg;
                            lf_next = fast_duty_reg;
                            rr_next = '0;
                            lr_next = '0;
                        end
                        else if (left_only)
                        begin
                            rf_next = '0;
                            lf_next = fast_duty_reg;
                            rr_next = '0;
                            lr_next = '0;
                        end
                        else if (right_only)
                        begin
                            rf_next = slow_duty_reg;
                            lf_next = '0;
                            rr_next = '0;
                            lr_next = '0;
                        end
                        else
                        begin
                            rf_next = '0;
                            lf_next = '0;
                            rr_next = slow_duty_reg;
                            lr_next = slow_duty_reg;
                        end
                    end
                    default: ;
                endcase
            end
            MODE_CMD:
            begin
                kind_next  = in_kind;
                rt_next    = in_rt;
                lt_next    = in_lt;
                state_next = ST_CONFIGURE;
            end
            MODE_FOLLOW:
                state_next = ST_FOLLOW;
            default: ;
        endcase
    end

    always_comb
    begin
        m_tdata_next = '0;
        m_tdata_next[0 +: DUTY_BITS]             = rf_next;
        m_tdata_next[DUTY_BITS +: DUTY_BITS]     = lf_next;
        m_tdata_next[2 * DUTY_BITS +: DUTY_BITS] = rr_next;
        m_tdata_next[3 * DUTY_BITS +: DUTY_BITS] = lr_next;
        m_tdata_next[OUT_CODE_LSB +: STATE_CODE_BITS] = state_code(state_next);
        m_tdata_next[OUT_FAULT_POS] = fault_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            kind_reg     <= '0;
            rf_reg       <= '0;
            lf_reg       <= '0;
            rr_reg       <= '0;
            lr_reg       <= '0;
            rt_reg       <= '0;
            lt_reg       <= '0;
            fault_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                kind_reg  <= kind_next;
                rf_reg    <= rf_next;
                lf_reg    <= lf_next;
                rr_reg    <= rr_next;
                lr_reg    <= lr_next;
                rt_reg    <= rt_next;
                lt_reg    <= lt_next;
                fault_reg <= fault_next;
            end
            if (accept)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            m_tdata_reg <= m_tdata_next;
    end

endmodule

[sv/dmrs_checker.sv]
// ----------------------------------------------------------------------------
// dmrs_checker
// Port-level checks for the dual motor ramp sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "dual_motor_ramp_sequencer_core_defines.svh"

module dmrs_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [dmrs_pkg::OUT_TDATA_BITS-1:0] m_tdata
);
    import dmrs_pkg::*;

    logic fault_seen_reg, fault_seen_next;
    logic out_idle;

    assign out_idle = m_tdata[OUT_CODE_LSB +: STATE_CODE_BITS] == CODE_IDLE;
    assign fault_seen_next = fault_seen_reg
                           || (m_tvalid && m_tready && m_tdata[OUT_FAULT_POS]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fault_seen_reg <= 1'b0;
        else
            fault_seen_reg <= fault_seen_next;
    end

    // held result blocks new items
    `DMRS_ASSERT_NOW(a_no_overrun, m_tvalid && !m_tready, !s_tready)
    `DMRS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // idle is only reached through stop, which clears every duty
    `DMRS_ASSERT_NOW(a_idle_off, m_tvalid && out_idle, m_tdata[OUT_CODE_LSB-1:0] == '0)
    // fault stays set until reset
    `DMRS_ASSERT_NOW(a_fault_sticky, m_tvalid && fault_seen_reg, m_tdata[OUT_FAULT_POS])

endmodule

bind dual_motor_ramp_sequencer_core dmrs_checker u_dmrs_checker (.*);
